>>> rtl/att_pkg.sv
`default_nettype none

package att_pkg;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_BEGIN,
		OP_NEXT,
		OP_NOP
	} op_t;

	localparam logic [1:0] ORD_PRE  = 2'd0;
	localparam logic [1:0] ORD_IN   = 2'd1;
	localparam logic [1:0] ORD_POST = 2'd2;

	typedef enum logic [1:0] {
		PH_ENTERED,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

	// Frames needed for the deepest tree a store of up to 65536 nodes can hold.
	localparam int STACK_DEPTH = 17;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BEGIN_CHK,
		ST_STEP_TOP,
		ST_STEP_VAL,
		ST_STEP_CHK,
		ST_EMIT_VAL,
		ST_EMIT_DONE
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic node_wr;
		logic rd_root;
		logic rd_top;
		logic rd_child;
		logic begin_walk;
		logic push_root;
		logic push_child;
		logic step_latch;
		logic end_walk;
		logic out_load;
		logic out_done;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_ready;
		logic top_right;
		logic child_ok;
		logic visit_top;
		logic visit_latched;
		logic visit_post;
		logic rd_nonzero;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/att_ctrl.sv
`default_nettype none

module att_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [1:0]    op,
	input  wire att_pkg::sts_t sts,
	output att_pkg::cmd_t      cmd,
	output logic               in_stall
);
	import att_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(op))
						OP_BEGIN: state_d = ST_BEGIN_CHK;
						OP_NEXT:  state_d = ST_STEP_TOP;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_BEGIN_CHK: state_d = ST_IDLE;
			ST_STEP_TOP: begin
				state_d = sts.walk_ready ? ST_STEP_VAL : ST_EMIT_DONE;
			end
			ST_STEP_VAL: begin
				if (sts.top_right) begin
					state_d = sts.visit_post ? ST_EMIT_VAL : ST_STEP_TOP;
				end else if (sts.child_ok) begin
					state_d = ST_STEP_CHK;
				end else begin
					state_d = sts.visit_top ? ST_EMIT_VAL : ST_STEP_TOP;
				end
			end
			ST_STEP_CHK: begin
				state_d = sts.visit_latched ? ST_EMIT_VAL : ST_STEP_TOP;
			end
			ST_EMIT_VAL, ST_EMIT_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(op))
						OP_WRITE: cmd.node_wr = 1'b1;
						OP_BEGIN: begin
							cmd.begin_walk = 1'b1;
							cmd.rd_root    = 1'b1;
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_BEGIN_CHK: cmd.push_root = sts.rd_nonzero;
			ST_STEP_TOP: begin
				cmd.rd_top   = sts.walk_ready;
				cmd.end_walk = !sts.walk_ready;
			end
			ST_STEP_VAL: begin
				cmd.step_latch = 1'b1;
				cmd.rd_child   = !sts.top_right && sts.child_ok;
			end
			ST_STEP_CHK: cmd.push_child = sts.rd_nonzero;
			ST_EMIT_VAL: cmd.out_load = sts.out_free;
			ST_EMIT_DONE: begin
				cmd.out_load = sts.out_free;
				cmd.out_done = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/att_dp.sv
`default_nettype none

module att_dp #(
	parameter int NODES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [9:0]         node_index,
	input  wire logic signed [31:0] node_data,
	input  wire logic [1:0]         walk_order,
	input  wire att_pkg::cmd_t      cmd,
	output att_pkg::sts_t           sts,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      visited_value,
	output logic                    walk_done
);
	import att_pkg::*;

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

	// Node store, single port, registered read.
	logic [31:0]   mem [NODES];
	logic [IW-1:0] addr;
	logic [31:0]   wdata;
	logic          we;
	logic          re;
	logic [31:0]   rd_q;

	logic [IW-1:0] clr_q;
	logic          node_in_range;

	logic [SP_W-1:0] sp_q;
	logic [SP_W-1:0] top_ptr;
	logic            active_q;
	logic [1:0]      order_q;
	logic [IW-1:0]   stk_idx_q [STACK_DEPTH];
	phase_t          stk_ph_q  [STACK_DEPTH];
	logic [IW-1:0]   top_idx;
	phase_t          top_ph;
	phase_t          next_ph;
	logic [IW+1:0]   child;

	logic [31:0]   value_q;
	phase_t        phase_q;
	logic [IW+1:0] child_q;

	logic               out_valid_q;
	logic signed [31:0] visited_value_q;
	logic               walk_done_q;
	logic               out_free;

	assign node_in_range = 32'(node_index) < NODES;
	assign top_ptr       = sp_q - SP_W'(1);
	assign top_idx       = stk_idx_q[top_ptr];
	assign top_ph        = stk_ph_q[top_ptr];
	// The right child of the last index needs two bits more than the store index.
	assign child         = {1'b0, top_idx, 1'b0}
	                     + ((top_ph == PH_ENTERED) ? (IW+2)'(1) : (IW+2)'(2));

	always_comb begin
		case (top_ph)
			PH_ENTERED: next_ph = PH_LEFT;
			default:    next_ph = PH_RIGHT;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		wdata = node_data;
		addr  = '0;
		if (cmd.clr_wr) begin
			we    = 1'b1;
			wdata = '0;
			addr  = clr_q;
		end else if (cmd.node_wr) begin
			we    = node_in_range;
			addr  = IW'(node_index);
		end else if (cmd.rd_top) begin
			addr  = top_idx;
		end else if (cmd.rd_child) begin
			addr  = child[IW-1:0];
		end
	end

	assign re = cmd.rd_root || cmd.rd_top || cmd.rd_child;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			active_q <= 1'b0;
			order_q  <= ORD_PRE;
		end else if (cmd.begin_walk) begin
			sp_q     <= '0;
			active_q <= 1'b1;
			order_q  <= walk_order;
		end else if (cmd.end_walk) begin
			sp_q     <= '0;
			active_q <= 1'b0;
		end else if (cmd.push_root || cmd.push_child) begin
			sp_q <= sp_q + SP_W'(1);
		end else if (cmd.step_latch && top_ph == PH_RIGHT) begin
			sp_q <= sp_q - SP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_root || cmd.push_child) begin
			stk_idx_q[sp_q] <= cmd.push_root ? '0 : child_q[IW-1:0];
			stk_ph_q[sp_q]  <= PH_ENTERED;
		end else if (cmd.step_latch && top_ph != PH_RIGHT) begin
			stk_ph_q[top_ptr] <= next_ph;
		end
	end

	// The visited value is taken from the top frame's read before the child read replaces it.
	always_ff @(posedge clk) begin
		if (cmd.step_latch) begin
			value_q <= rd_q;
			phase_q <= top_ph;
			child_q <= child;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			visited_value_q <= cmd.out_done ? '0 : value_q;
			walk_done_q     <= cmd.out_done;
		end
	end

	assign out_valid     = out_valid_q;
	assign visited_value = visited_value_q;
	assign walk_done     = walk_done_q;

	always_comb begin
		sts.clr_last      = (clr_q == IW'(NODES - 1));
		sts.walk_ready    = active_q && (sp_q != '0);
		sts.top_right     = (top_ph == PH_RIGHT);
		sts.child_ok      = (32'(child) < NODES) && (sp_q < SP_W'(STACK_DEPTH));
		sts.visit_top     = (order_q == ORD_PRE && top_ph == PH_ENTERED)
		                 || (order_q == ORD_IN && top_ph == PH_LEFT);
		sts.visit_latched = (order_q == ORD_PRE && phase_q == PH_ENTERED)
		                 || (order_q == ORD_IN && phase_q == PH_LEFT);
		sts.visit_post    = (order_q >= ORD_POST);
		sts.rd_nonzero    = (rd_q != '0);
		sts.out_free      = out_free;
	end

endmodule

`default_nettype wire

>>> rtl/array_tree_traversal.sv
// Binary tree walker over a node store held in on-chip memory.
// Input channel (in_valid / in_stall) carries one transaction per command:
// op selects a node write, the start of a walk, a request for the next
// visited node, or no operation. Only a next request produces a
// transaction on the output channel (out_valid / out_stall), carrying
// visited_value and walk_done. Each step of a next request reads the
// single-port node store once for the top frame and once more for the
// child it may push; one command is in work at a time.
// After reset all NODES store entries are cleared, one entry per
// cycle, during which in_stall stays high. Stack and walk state reset to idle.
// The result sits in an output register: while the receiver stalls it holds,
// and the next command is still accepted; only a further result waits until
// the register is free.
`default_nettype none

module array_tree_traversal #(
	parameter int NODES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic [9:0]         node_index,
	input  wire logic signed [31:0] node_data,
	input  wire logic [1:0]         walk_order,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      visited_value,
	output logic                    walk_done
);
	import att_pkg::*;

	cmd_t cmd;
	sts_t sts;

	att_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	att_dp #(
		.NODES (NODES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.node_index    (node_index),
		.node_data     (node_data),
		.walk_order    (walk_order),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.visited_value (visited_value),
		.walk_done     (walk_done)
	);

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import att_pkg::*;

	localparam int NODE_COUNT = 1024;
	localparam int ITEM_TARGET = 1950;
	localparam int HOLD_CYCLES = 400;
	localparam int INTRO_ROWS = 25;
	localparam logic [1:0] ORD_SPARE = 2'd3;

	typedef struct {
		logic signed [31:0] value;
		logic               done;
	} visit_t;

	typedef struct {
		op_t                op;
		logic [9:0]         idx;
		logic signed [31:0] data;
		logic [1:0]         ord;
		bit                 typed;
		logic signed [31:0] want_value;
		logic               want_done;
	} cmd_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic [9:0]         node_index;
	logic signed [31:0] node_data;
	logic [1:0]         walk_order;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] visited_value;
	logic               walk_done;

	// Shadow copy of the block's tree and walk state.
	logic signed [31:0] shadow_store [NODE_COUNT];
	int unsigned        frame_node [STACK_DEPTH];
	phase_t             frame_phase [STACK_DEPTH];
	int unsigned        depth_used;
	logic [1:0]         walk_ord;
	bit                 walk_on;

	visit_t   pending_visits [$];
	cmd_row_t intro_rows [INTRO_ROWS];
	int       mismatches;
	int       items_sent;
	int       sender_idle_pct;
	int       rx_stall_pct;
	int       hold_left;
	bit       walk_finished;

	array_tree_traversal #(
		.NODES(NODE_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.node_index(node_index),
		.node_data(node_data),
		.walk_order(walk_order),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visited_value(visited_value),
		.walk_done(walk_done)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic void push_present(input int unsigned child);
		if (child < NODE_COUNT && depth_used < STACK_DEPTH) begin
			if (shadow_store[child] != 0) begin
				frame_node[depth_used] = child;
				frame_phase[depth_used] = PH_ENTERED;
				depth_used++;
			end
		end
	endfunction

	// Returns 1 when the command yields a result transaction.
	function automatic bit apply_command(input op_t c_op, input logic [9:0] c_idx,
			input logic signed [31:0] c_data, input logic [1:0] c_ord,
			output logic signed [31:0] v_out, output logic d_out);
		int unsigned top;
		int unsigned node;
		logic signed [31:0] node_val;
		v_out = 32'sd0;
		d_out = 1'b1;
		case (c_op)
		OP_WRITE: begin
			if (c_idx < NODE_COUNT)
				shadow_store[c_idx] = c_data;
			return 1'b0;
		end
		OP_BEGIN: begin
			depth_used = 0;
			walk_ord = c_ord;
			walk_on = 1'b1;
			push_present(0);
			return 1'b0;
		end
		OP_NEXT: begin
			while (walk_on && depth_used > 0) begin
				top = depth_used - 1;
				node = frame_node[top];
				node_val = shadow_store[node];
				case (frame_phase[top])
				PH_ENTERED: begin
					frame_phase[top] = PH_LEFT;
					push_present(2 * node + 1);
					if (walk_ord == ORD_PRE) begin
						v_out = node_val;
						d_out = 1'b0;
						return 1'b1;
					end
				end
				PH_LEFT: begin
					frame_phase[top] = PH_RIGHT;
					push_present(2 * node + 2);
					if (walk_ord == ORD_IN) begin
						v_out = node_val;
						d_out = 1'b0;
						return 1'b1;
					end
				end
				default: begin
					depth_used--;
					if (walk_ord >= ORD_POST) begin
						v_out = node_val;
						d_out = 1'b0;
						return 1'b1;
					end
				end
				endcase
			end
			walk_on = 1'b0;
			depth_used = 0;
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_nonzero();
		logic [31:0] d;
		do
			d = $urandom;
		while (d == 0);
		return d;
	endfunction

	task automatic send_row(input cmd_row_t r);
		logic signed [31:0] pv;
		logic pd;
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= r.op;
		node_index <= r.idx;
		node_data <= r.data;
		walk_order <= r.ord;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (apply_command(r.op, r.idx, r.data, r.ord, pv, pd)) begin
			walk_finished = pd;
			if (r.typed) begin
				pv = r.want_value;
				pd = r.want_done;
			end
			pending_visits.push_back('{pv, pd});
		end
		if (r.op != OP_NOP)
			items_sent++;
	endtask

	task automatic send_cmd(input op_t c_op, input logic [9:0] c_idx,
			input logic signed [31:0] c_data, input logic [1:0] c_ord);
		cmd_row_t r;
		r = '{c_op, c_idx, c_data, c_ord, 1'b0, 32'sd0, 1'b0};
		send_row(r);
	endtask

	// Receiver side: random stalls, plus one long hold-off to back the block up.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		visit_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_visits.size() == 0) begin
				$display("%0t: result with nothing expected: visited_value %0d walk_done %0b",
					$time, visited_value, walk_done);
				mismatches++;
			end else begin
				want = pending_visits.pop_front();
				if (visited_value !== want.value) begin
					$display("%0t: visited_value expected %0d actual %0d",
						$time, want.value, visited_value);
					mismatches++;
				end
				if (walk_done !== want.done) begin
					$display("%0t: walk_done expected %0b actual %0b",
						$time, want.done, walk_done);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int k;
		int n;
		int leaf;
		int pick;
		bit pressure_done;

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_NOP;
		node_index = '0;
		node_data = '0;
		walk_order = ORD_PRE;
		mismatches = 0;
		items_sent = 0;
		sender_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		walk_finished = 1'b0;
		pressure_done = 1'b0;
		for (k = 0; k < NODE_COUNT; k++)
			shadow_store[k] = 32'sd0;
		depth_used = 0;
		walk_ord = ORD_PRE;
		walk_on = 1'b0;

		intro_rows = '{
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b1, 32'sd0,         1'b1},
			'{OP_BEGIN, 10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b1, 32'sd0,         1'b1},
			'{OP_NEXT,  10'h3FF, 32'sd0,         ORD_IN,    1'b1, 32'sd0,         1'b1},
			'{OP_WRITE, 10'd0,   32'h7FFF_FFFF,  ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_WRITE, 10'd1,   32'h8000_0000,  ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_WRITE, 10'd2,   32'hFFFF_FFFF,  ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_WRITE, 10'h3FF, 32'sd1,         ORD_POST,  1'b0, 32'sd0,         1'b0},
			'{OP_BEGIN, 10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b1, 32'h7FFF_FFFF,  1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b1, 32'h8000_0000,  1'b0},
			'{OP_WRITE, 10'd2,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b1, 32'sd0,         1'b1},
			'{OP_WRITE, 10'd2,   32'h1234_5678,  ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_BEGIN, 10'd0,   32'sd0,         ORD_IN,    1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_BEGIN, 10'd0,   32'sd0,         ORD_SPARE, 1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NOP,   10'h3FF, 32'hFFFF_FFFF,  ORD_SPARE, 1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_BEGIN, 10'd0,   32'sd0,         ORD_POST,  1'b0, 32'sd0,         1'b0},
			'{OP_WRITE, 10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0},
			'{OP_NEXT,  10'd0,   32'sd0,         ORD_PRE,   1'b0, 32'sd0,         1'b0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < INTRO_ROWS; k++)
			send_row(intro_rows[k]);

		while (items_sent < ITEM_TARGET) begin
			case (items_sent * 5 / ITEM_TARGET)
			0: begin
				sender_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 47;
				rx_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				rx_stall_pct = 47;
			end
			3: begin
				sender_idle_pct = 9;
				rx_stall_pct = 9;
			end
			default: begin
				sender_idle_pct = 0;
				rx_stall_pct = 0;
			end
			endcase

			if ($urandom_range(99) < 70) begin
				// Keep the tree small so that walks stay short.
				n = 0;
				for (k = 0; k < NODE_COUNT; k++)
					if (shadow_store[k] != 0)
						n++;
				if (n > 24)
					for (k = 0; k < NODE_COUNT; k++)
						if (shadow_store[k] != 0)
							send_cmd(OP_WRITE, 10'(k), 32'sd0, 2'($urandom_range(3)));

				if ($urandom_range(99) < 15) begin
					// A full-depth path, sometimes down to the last index, whose
					// children fall beyond the store.
					leaf = ($urandom_range(3) == 0) ? NODE_COUNT - 1
						: $urandom_range(NODE_COUNT - 2, NODE_COUNT / 2 - 1);
					for (k = leaf; k > 0; k = (k - 1) / 2)
						send_cmd(OP_WRITE, 10'(k), rand_nonzero(), 2'($urandom_range(3)));
					send_cmd(OP_WRITE, 10'd0, rand_nonzero(), 2'($urandom_range(3)));
				end else begin
					n = $urandom_range(9, 2);
					send_cmd(OP_WRITE, 10'd0,
						($urandom_range(9) == 0) ? 32'sd0 : rand_nonzero(),
						2'($urandom_range(3)));
					repeat (n)
						send_cmd(OP_WRITE, 10'($urandom_range(14, 1)),
							($urandom_range(7) == 0) ? 32'sd0 : rand_nonzero(),
							2'($urandom_range(3)));
				end

				send_cmd(OP_BEGIN, 10'($urandom), $urandom, 2'($urandom_range(3)));
				walk_finished = 1'b0;
				if (items_sent * 5 / ITEM_TARGET >= 4 && !pressure_done) begin
					hold_left = HOLD_CYCLES;
					pressure_done = 1'b1;
				end
				while (!walk_finished) begin
					pick = $urandom_range(99);
					if (pick < 4)
						send_cmd(OP_WRITE, 10'($urandom_range(30)),
							$urandom_range(1) ? rand_nonzero() : 32'sd0,
							2'($urandom_range(3)));
					else if (pick < 6)
						send_cmd(OP_BEGIN, 10'($urandom), $urandom,
							2'($urandom_range(3)));
					else if (pick < 8)
						send_cmd(OP_NOP, 10'($urandom), $urandom, 2'($urandom_range(3)));
					else
						send_cmd(OP_NEXT, 10'($urandom), $urandom, 2'($urandom_range(3)));
				end
				repeat ($urandom_range(2))
					send_cmd(OP_NEXT, 10'($urandom), $urandom, 2'($urandom_range(3)));
			end else begin
				repeat ($urandom_range(6, 1))
					send_cmd(op_t'($urandom_range(3)), 10'($urandom), $urandom,
						2'($urandom_range(3)));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_visits.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
